[hw/rtl/fph_pkg.sv]
// Shared types and codes for the fit-policy hole allocator.
package fph_pkg;

    localparam int SLOT_W = 4;
    localparam int AMT_W  = 16;
    localparam int MODE_W = 2;
    localparam int CNT_IN_W = 5;

    // Input kind codes
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // Placement policy codes
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;
    localparam logic [MODE_W-1:0] FIT_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_FIT_MODE   = 1'b0;
    localparam logic CFG_HOLE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              success;
        logic [SLOT_W-1:0] placed_slot;
        logic [AMT_W-1:0]  remaining;
    } res_t;

endpackage

[hw/rtl/fph_mem.sv]
// Hole size table: one write port, one read port with registered read data.
module fph_mem
    import fph_pkg::*;
#(
    parameter int HOLES     = 16,
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  logic [SIZE_BITS-1:0] wdata,
    input  logic [IDX_W-1:0]     raddr,
    output logic [SIZE_BITS-1:0] rdata
);

    logic [SIZE_BITS-1:0] mem [HOLES];
    logic [SIZE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fph_scan.sv]
// Request sequencer: load writes, allocation scan over the table, write-back of the pick.
module fph_scan
    import fph_pkg::*;
#(
    parameter int HOLES     = 16,
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4,
    parameter int ACT_W     = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [AMT_W-1:0]      amount,
    input  logic [MODE_W-1:0]     fit_mode,
    input  logic [CNT_IN_W-1:0]   hole_count,
    output logic                  res_valid,
    input  logic                  res_take,
    output res_t                  res
);

    state_t               state_reg, state_next;
    logic [ACT_W-1:0]     idx_reg, idx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;
    logic [AMT_W-1:0]     amt_reg, amt_next;
    res_t                 res_reg, res_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic [SIZE_BITS-1:0] mem_rdata;

    logic [ACT_W-1:0]     active;
    logic                 slot_ok;
    logic [SIZE_BITS-1:0] load_size;
    logic [SIZE_BITS-1:0] left;
    logic                 fits;
    logic                 take;

    fph_mem #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    // Entries searched: hole count saturated to the table depth, none for the undefined mode.
    always_comb
    begin
        if (fit_mode == FIT_NONE)
            active = '0;
        else if (32'(hole_count) > HOLES)
            active = ACT_W'(HOLES);
        else
            active = ACT_W'(hole_count);
    end

    assign slot_ok   = 32'(slot) < HOLES;
    assign load_size = SIZE_BITS'(32'(amount));
    assign left      = SIZE_BITS'(32'(best_reg) - 32'(amt_reg));
    assign fits      = 32'(mem_rdata) >= 32'(amt_reg);

    always_comb
    begin
        if (!found_reg)
            take = 1'b1;
        else
        begin
            unique case (fit_mode)
                FIT_BEST:  take = mem_rdata < best_reg;
                FIT_WORST: take = mem_rdata > best_reg;
                default:   take = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        rd_pend_next = rd_pend_reg;
        rd_idx_next  = rd_idx_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        amt_next     = amt_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = pick_reg;
        mem_wdata    = left;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        if (slot_ok)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = IDX_W'(slot);
                            mem_wdata = load_size;
                            res_next  = '{success: 1'b1, placed_slot: slot,
                                          remaining: AMT_W'(32'(load_size))};
                        end
                        else
                        begin
                            res_next = '0;
                        end
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        amt_next     = amount;
                        idx_next     = '0;
                        found_next   = 1'b0;
                        rd_pend_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle; compare the entry that returns.
                rd_pend_next = 1'b0;
                if (idx_reg < active)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = idx_reg[IDX_W-1:0];
                    idx_next     = ACT_W'(idx_reg + 1'b1);
                end
                if (rd_pend_reg && fits && take)
                begin
                    found_next = 1'b1;
                    pick_next  = rd_idx_reg;
                    best_next  = mem_rdata;
                end
                if (idx_reg >= active && !rd_pend_reg)
                begin
                    if (found_reg)
                    begin
                        mem_we   = 1'b1;
                        res_next = '{success: 1'b1,
                                     placed_slot: SLOT_W'(32'(pick_reg)),
                                     remaining: AMT_W'(32'(left))};
                    end
                    else
                    begin
                        res_next = '0;
                    end
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_take)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        pick_reg   <= pick_next;
        best_reg   <= best_next;
        amt_reg    <= amt_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

    // A pending read always lands while still scanning.
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> state_reg == ST_SCAN)
        else $error("read data returned outside scan");

    // The held pick always fits the request.
    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && found_reg) |-> 32'(best_reg) >= 32'(amt_reg))
        else $error("chosen hole smaller than request");

    // The scan pointer never runs past the active entries.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> idx_reg <= active)
        else $error("scan index beyond active entries");

    // Hold the finished result steady until the output stage takes it.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && !res_take) |=> $stable(res_reg))
        else $error("result changed while waiting");

endmodule

[hw/rtl/fit_policy_hole_allocator.sv]
// Top level of the fit-policy hole allocator: stream ports, configuration and output stage.
// A load request writes the table and registers its result in the sequencer; an allocate
//   request scans the active entries, one table read per scan cycle, then writes back the pick.
// Requests are taken one at a time: a new request is accepted only after the previous
//   result has passed to the output register.
// Reset (rst_n, async, active low): fit_mode = first fit, hole_count = 16, no request held.
//   The hole table is not cleared; entries read before being loaded hold no defined size.
module fit_policy_hole_allocator
    import fph_pkg::*;
#(
    parameter int HOLES     = 16,
    parameter int SIZE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [3:0] slot, [19:4] amount, [23:20] zero
    input  logic        s_tuser,    // [0] kind
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [3:0] placed_slot, [19:4] remaining, [23:20] zero
    output logic        m_tuser,    // [0] success
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int IDX_W  = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CNT_W  = $clog2(HOLES + 1);
    localparam int ACT_W  = (CNT_W > CNT_IN_W) ? CNT_W : CNT_IN_W;

    logic [MODE_W-1:0]   fit_mode_reg;
    logic [CNT_IN_W-1:0] hole_count_reg;

    logic out_valid_reg;
    res_t out_res_reg;

    logic res_valid;
    logic res_take;
    res_t res;

    // Configuration: always ready; writes must arrive only while idle, and the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= FIT_FIRST;
            hole_count_reg <= CNT_IN_W'(16);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FIT_MODE:   fit_mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_HOLE_COUNT: hole_count_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    fph_scan #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W),
        .ACT_W     (ACT_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .kind       (s_tuser),
        .slot       (s_tdata[SLOT_W-1:0]),
        .amount     (s_tdata[SLOT_W+AMT_W-1:SLOT_W]),
        .fit_mode   (fit_mode_reg),
        .hole_count (hole_count_reg),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    // Output register: take a new result when empty or being drained this cycle,
    // so the sequencer can move on while the consumer stalls.
    assign res_take = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.success;
    assign m_tdata  = {4'b0, out_res_reg.remaining, out_res_reg.placed_slot};

    // A failed result carries zero slot and zero size.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.success) |->
            (out_res_reg.placed_slot == '0 && out_res_reg.remaining == '0))
        else $error("failed result with nonzero fields");

    // No new request is taken while the previous one is still in flight.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // A pending result is held until the output stage takes it.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> res_valid)
        else $error("result dropped before output stage");

endmodule
